### hw/rtl/oce_pkg.sv
// Shared types and constants for the order crossover engine.
`default_nettype none

package oce_pkg;

	// Field widths fixed by the interface.
	localparam int TASK_W = 16;
	localparam int NODE_W = 16;
	localparam int POS_W  = 6;
	localparam int LEN_W  = 7;

	// Chromosome length after reset.
	localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

	// Command codes.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_RUN  = 1'b1;

	// Result status codes.
	localparam logic ST_OK        = 1'b0;
	localparam logic ST_BAD_SLICE = 1'b1;

	// One gene: a task id with the node id that travels with it.
	typedef struct packed {
		logic [TASK_W-1:0] task_id;
		logic [NODE_W-1:0] node_id;
	} gene_t;

	// A second-parent gene moving round the ring, with its slice-hit flag.
	typedef struct packed {
		gene_t gene;
		logic  hit;
	} token_t;

	// Controls broadcast from the sequencer to every cell.
	typedef struct packed {
		logic load;
		logic init;
		logic cmp;
		logic p2_rot;
		logic off_rot;
	} cell_ctrl_t;

	// Run sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_FILL,
		S_ALIGN,
		S_EMIT
	} state_t;

endpackage

`default_nettype wire

### hw/rtl/oce_cell.sv
// One gene position of the crossover ring: both parents, the offspring and the slice flags.
`default_nettype none

module oce_cell (
	input  wire logic                clk,
	input  wire oce_pkg::cell_ctrl_t ctrl,
	input  wire logic                ld_sel,
	input  wire logic                in_slice,
	input  wire logic                active,
	input  wire logic                is_tail,
	input  wire oce_pkg::gene_t      ld_p1,
	input  wire oce_pkg::gene_t      ld_p2,
	input  wire oce_pkg::token_t     tok_nbr,
	input  wire oce_pkg::token_t     tok_wrap,
	input  wire oce_pkg::gene_t      off_nbr,
	input  wire oce_pkg::gene_t      off_wrap,
	output oce_pkg::token_t          tok_out,
	output oce_pkg::gene_t           off_out
);

	oce_pkg::gene_t  p1_q;
	oce_pkg::gene_t  p2_q;
	oce_pkg::gene_t  off_q;
	logic            hit_q;
	logic            slice_q;
	logic            hit_now;
	oce_pkg::token_t tok_sel;
	oce_pkg::gene_t  off_sel;

	// The passing token picks up a hit when this slice cell holds the same task id.
	always_comb begin
		hit_now = hit_q | (ctrl.cmp & slice_q & (p1_q.task_id == p2_q.task_id));
		tok_out = '{gene: p2_q, hit: hit_now};
		off_out = off_q;
		tok_sel = is_tail ? tok_wrap : tok_nbr;
		off_sel = is_tail ? off_wrap : off_nbr;
	end

	// First parent is written by loads only and never moves.
	always_ff @(posedge clk) begin
		if (ctrl.load && ld_sel) begin
			p1_q <= ld_p1;
		end
	end

	// Second parent is loaded in place and rotates during a run, carrying its hit flag.
	always_ff @(posedge clk) begin
		if (ctrl.load && ld_sel) begin
			p2_q <= ld_p2;
		end else if (ctrl.init) begin
			hit_q <= 1'b0;
		end else if (ctrl.p2_rot && active) begin
			p2_q  <= tok_sel.gene;
			hit_q <= tok_sel.hit;
		end
	end

	// Offspring starts as the kept slice with zeros elsewhere, then rotates as it is filled, realigned and emitted.
	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			slice_q <= in_slice;
			off_q   <= in_slice ? p1_q : '0;
		end else if (ctrl.off_rot && active) begin
			off_q <= off_sel;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/order_crossover_engine.sv
// Top level of the order crossover engine: command port, run sequencer and the ring of cells.
`default_nettype none

// A load transaction writes one gene of each parent and busy stays low.
// A run transaction with a bad slice gives its single error result in the next cycle.
// A good run on a chromosome of length n keeps busy high while the sequencer rotates the
// second parent once round the ring of cells to mark genes whose task is in the slice,
// scans it in order to fill the offspring, turns the offspring ring back to position
// zero and streams the offspring out from cell zero. Results come one per cycle on
// out_valid and cannot be held off; the last one shows while busy has already fallen.
module order_crossover_engine #(
	parameter int MAX_GENES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cmd,
	input  wire logic [5:0]  position,
	input  wire logic [15:0] first_task,
	input  wire logic [15:0] first_node,
	input  wire logic [15:0] second_task,
	input  wire logic [15:0] second_node,
	input  wire logic [5:0]  slice_begin,
	input  wire logic [5:0]  slice_end,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [6:0]  cfg_data,
	output logic             out_valid,
	output logic [5:0]       out_position,
	output logic [15:0]      out_task,
	output logic [15:0]      out_node,
	output logic             is_last,
	output logic             status
);

	localparam int IW = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;
	localparam int NW = $clog2(MAX_GENES + 1);
	localparam int CW = $clog2(2 * MAX_GENES + 1);
	localparam int XW = (CW > oce_pkg::POS_W) ? CW : oce_pkg::POS_W;
	localparam int LW = (NW > oce_pkg::LEN_W) ? NW : oce_pkg::LEN_W;

	oce_pkg::state_t           state_q;
	oce_pkg::state_t           state_d;
	logic [oce_pkg::LEN_W-1:0] len_q;
	logic [NW-1:0]             n_q;
	logic [NW-1:0]             n_eff;
	logic [5:0]                b_q;
	logic [5:0]                e_q;
	logic [XW-1:0]             cnt_q;
	logic [IW-1:0]             fill_q;
	logic [IW-1:0]             ofs_q;

	logic                      out_valid_q;
	logic [5:0]                out_position_q;
	logic [15:0]               out_task_q;
	logic [15:0]               out_node_q;
	logic                      is_last_q;
	logic                      status_q;

	logic                      accept;
	logic                      slice_good;
	logic                      run_ok;
	logic                      run_bad;
	logic [XW-1:0]             n_x;
	logic [XW-1:0]             e_x;
	logic [XW-1:0]             e_in_x;
	logic [XW-1:0]             b_in_x;
	logic                      ring_last;
	logic                      scan_last;
	logic                      pre_win;
	logic                      in_win;
	logic                      fill_open;
	logic                      fill_wr;
	logic [IW-1:0]             fill_inc;
	logic [IW-1:0]             ofs_inc;
	oce_pkg::cell_ctrl_t       ctrl;

	oce_pkg::gene_t            ld_p1;
	oce_pkg::gene_t            ld_p2;
	oce_pkg::token_t           tok_out [MAX_GENES];
	oce_pkg::gene_t            off_out [MAX_GENES];
	oce_pkg::gene_t            off_wrap;
	logic [MAX_GENES-1:0]      ld_sel;
	logic [MAX_GENES-1:0]      in_slice;
	logic [MAX_GENES-1:0]      active;
	logic [MAX_GENES-1:0]      is_tail;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= oce_pkg::LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			len_q <= cfg_data;
		end
	end

	// Effective length: zero acts as one, anything above the ring size is clamped.
	always_comb begin
		if (len_q == '0) begin
			n_eff = NW'(1);
		end else if (LW'(len_q) > LW'(MAX_GENES)) begin
			n_eff = NW'(MAX_GENES);
		end else begin
			n_eff = NW'(len_q);
		end
	end

	// Command transaction decode and slice check.
	always_comb begin
		accept     = start && !busy;
		e_in_x     = XW'(slice_end);
		b_in_x     = XW'(slice_begin);
		slice_good = (b_in_x <= e_in_x) && (e_in_x < XW'(n_eff));
		run_ok     = accept && (cmd == oce_pkg::CMD_RUN) && slice_good;
		run_bad    = accept && (cmd == oce_pkg::CMD_RUN) && !slice_good;
	end

	// Step counter windows for the current run.
	always_comb begin
		n_x       = XW'(n_q);
		e_x       = XW'(e_q);
		ring_last = (cnt_q == n_x - XW'(1));
		scan_last = (cnt_q == (n_x << 1) - XW'(1));
		pre_win   = (cnt_q <= e_x);
		in_win    = (cnt_q > e_x) && (cnt_q <= e_x + n_x);
		fill_open = (XW'(fill_q) != XW'(b_q));
		fill_inc  = (XW'(fill_q) == n_x - XW'(1)) ? '0 : fill_q + IW'(1);
		ofs_inc   = (XW'(ofs_q) == n_x - XW'(1)) ? '0 : ofs_q + IW'(1);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oce_pkg::S_IDLE: begin
				if (run_ok) begin
					state_d = oce_pkg::S_MATCH;
				end
			end
			oce_pkg::S_MATCH: begin
				if (ring_last) begin
					state_d = oce_pkg::S_FILL;
				end
			end
			oce_pkg::S_FILL: begin
				if (scan_last) begin
					state_d = oce_pkg::S_ALIGN;
				end
			end
			oce_pkg::S_ALIGN: begin
				if (ofs_q == '0) begin
					state_d = oce_pkg::S_EMIT;
				end
			end
			oce_pkg::S_EMIT: begin
				if (ring_last) begin
					state_d = oce_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = oce_pkg::S_IDLE;
			end
		endcase
	end

	// Sequencer outputs: cell controls, the fill write and busy.
	always_comb begin
		busy         = (state_q != oce_pkg::S_IDLE);
		cfg_ready    = !busy;
		fill_wr      = (state_q == oce_pkg::S_FILL) && in_win && !tok_out[0].hit && fill_open;
		ctrl.load    = accept && (cmd == oce_pkg::CMD_LOAD);
		ctrl.init    = run_ok;
		ctrl.cmp     = (state_q == oce_pkg::S_MATCH);
		ctrl.p2_rot  = (state_q == oce_pkg::S_MATCH) || (state_q == oce_pkg::S_FILL);
		ctrl.off_rot = ((state_q == oce_pkg::S_FILL) && (pre_win || fill_wr)) ||
		               ((state_q == oce_pkg::S_ALIGN) && (ofs_q != '0)) ||
		               (state_q == oce_pkg::S_EMIT);
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oce_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Run counters: step count, next fill position and offspring ring offset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			fill_q <= '0;
			ofs_q  <= '0;
			n_q    <= NW'(1);
			b_q    <= '0;
			e_q    <= '0;
		end else begin
			unique case (state_q)
				oce_pkg::S_IDLE: begin
					if (run_ok) begin
						cnt_q  <= '0;
						ofs_q  <= '0;
						n_q    <= n_eff;
						b_q    <= slice_begin;
						e_q    <= slice_end;
						fill_q <= (e_in_x + XW'(1) == XW'(n_eff)) ? '0 : IW'(e_in_x + XW'(1));
					end
				end
				oce_pkg::S_MATCH: begin
					cnt_q <= ring_last ? '0 : cnt_q + XW'(1);
				end
				oce_pkg::S_FILL: begin
					cnt_q <= scan_last ? '0 : cnt_q + XW'(1);
					if (fill_wr) begin
						fill_q <= fill_inc;
					end
					if (pre_win || fill_wr) begin
						ofs_q <= ofs_inc;
					end
				end
				oce_pkg::S_ALIGN: begin
					if (ofs_q != '0) begin
						ofs_q <= ofs_inc;
					end
				end
				oce_pkg::S_EMIT: begin
					cnt_q <= ring_last ? '0 : cnt_q + XW'(1);
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= run_bad || (state_q == oce_pkg::S_EMIT);
		end
	end

	// Result payload: the error result or the offspring gene at the ring head.
	always_ff @(posedge clk) begin
		if (run_bad) begin
			out_position_q <= '0;
			out_task_q     <= '0;
			out_node_q     <= '0;
			is_last_q      <= 1'b1;
			status_q       <= oce_pkg::ST_BAD_SLICE;
		end else if (state_q == oce_pkg::S_EMIT) begin
			out_position_q <= 6'(cnt_q);
			out_task_q     <= off_out[0].task_id;
			out_node_q     <= off_out[0].node_id;
			is_last_q      <= ring_last;
			status_q       <= oce_pkg::ST_OK;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_position = out_position_q;
	assign out_task     = out_task_q;
	assign out_node     = out_node_q;
	assign is_last      = is_last_q;
	assign status       = status_q;

	// Load data and the head write into the wrap path of the offspring ring.
	assign ld_p1    = '{task_id: first_task, node_id: first_node};
	assign ld_p2    = '{task_id: second_task, node_id: second_node};
	assign off_wrap = fill_wr ? tok_out[0].gene : off_out[0];

	// Row of cells; cell n-1 closes the ring from cell zero.
	for (genvar i = 0; i < MAX_GENES; i++) begin : g_cell
		assign ld_sel[i]   = (XW'(i) == XW'(position));
		assign in_slice[i] = (XW'(i) >= b_in_x) && (XW'(i) <= e_in_x);
		assign active[i]   = (XW'(i) < n_x);
		assign is_tail[i]  = (XW'(i) == n_x - XW'(1));

		if (i == MAX_GENES - 1) begin : g_end
			oce_cell u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.ld_sel   (ld_sel[i]),
				.in_slice (in_slice[i]),
				.active   (active[i]),
				.is_tail  (is_tail[i]),
				.ld_p1    (ld_p1),
				.ld_p2    (ld_p2),
				.tok_nbr  (tok_out[0]),
				.tok_wrap (tok_out[0]),
				.off_nbr  (off_wrap),
				.off_wrap (off_wrap),
				.tok_out  (tok_out[i]),
				.off_out  (off_out[i])
			);
		end else begin : g_mid
			oce_cell u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.ld_sel   (ld_sel[i]),
				.in_slice (in_slice[i]),
				.active   (active[i]),
				.is_tail  (is_tail[i]),
				.ld_p1    (ld_p1),
				.ld_p2    (ld_p2),
				.tok_nbr  (tok_out[i+1]),
				.tok_wrap (tok_out[0]),
				.off_nbr  (off_out[i+1]),
				.off_wrap (off_wrap),
				.tok_out  (tok_out[i]),
				.off_out  (off_out[i])
			);
		end
	end

`ifndef ASSERT_OFF
	// The fill position never lands inside the kept slice.
	a_fill_outside_slice: assert property (@(posedge clk) disable iff (!arst_n)
		fill_wr |-> !((XW'(fill_q) >= XW'(b_q)) && (XW'(fill_q) <= XW'(e_q))))
		else $error("offspring fill entered the kept slice");

	// An error result stands alone, at position zero.
	a_error_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == oce_pkg::ST_BAD_SLICE)) |-> (is_last && (out_position == '0)))
		else $error("error result not marked last or not at position zero");

	// Offspring genes stream out back to back with rising positions.
	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_last) |=> (out_valid && (out_position == $past(out_position) + 6'd1)))
		else $error("offspring stream broken or out of order");

	// The ring offset is back at zero whenever a gene is streamed out.
	a_emit_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == oce_pkg::S_EMIT) |-> (ofs_q == '0))
		else $error("offspring ring not aligned during emission");
`endif

endmodule

`default_nettype wire
